// ----- src/image_box_downscale_defines.svh -----
// Assertion macros shared by the image box downscaler RTL.
// Expects signals named clock and reset in the including module.
`ifndef IMAGE_BOX_DOWNSCALE_DEFINES_SVH
`define IMAGE_BOX_DOWNSCALE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IBD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/ibd_pkg.sv -----
// Shared widths, register indexes and types for the image box downscaler.
// No dependencies; imported by ibd_div, image_box_downscale, the checker and the testbench.
package ibd_pkg;

   localparam int DIM_W     = 13;
   localparam int CHAN_W    = 8;
   localparam int SUM_W     = 32;
   localparam int CNT_W     = 2 * DIM_W;
   localparam int TB_W      = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXEL_BYTES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HEIGHT  = 3'd4;

   localparam logic [TB_W-1:0]   MIN_TEXEL_BYTES = 4'd3;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE    = 8'hFF;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- src/ibd_div.sv -----
// Restoring divider, one quotient bit per cycle, for the image box downscaler.
// Depends on ibd_pkg for operand widths and the status struct.
module ibd_div import ibd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic [SUM_W-1:0] quotient,
   output div_stat_type     status
);

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsor_ff, dsor_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = trial - {1'b0, dsor_ff};
      fits    = trial >= {1'b0, dsor_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dsor_in = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
      quo_ff  <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- src/image_box_downscale.sv -----
// Integer box-filter image downscaler: one texel per cycle into a column-sum line store,
// except while stalled. A box-completing texel holds the input while three 32-step dividers
// form the averages; the input is also held while the box geometry is set up.
// A write to one of the five registers restarts setup of the step and thumbnail size.
// Synchronous active-high reset restores the default registers; line store is not cleared.
`include "image_box_downscale_defines.svh"

module image_box_downscale import ibd_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CHAN_W-1:0]    req_chan_a,
   input  logic [CHAN_W-1:0]    req_chan_b,
   input  logic [CHAN_W-1:0]    req_chan_c,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAN_W-1:0]    rsp_red,
   output logic [CHAN_W-1:0]    rsp_green,
   output logic [CHAN_W-1:0]    rsp_blue,
   output logic [CHAN_W-1:0]    rsp_alpha,
   output logic [DIM_W-1:0]     rsp_out_cols,
   output logic [DIM_W-1:0]     rsp_out_rows,
   output logic                 rsp_last_pixel,
   output logic                 rsp_rejected,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   localparam int SLOT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WIDTH - 1);
   localparam int LINE_W = 3 * SUM_W;

   typedef enum logic [7:0] {
      ST_SETUP_A = 8'b0000_0001,
      ST_WAIT_A  = 8'b0000_0010,
      ST_SETUP_B = 8'b0000_0100,
      ST_WAIT_B  = 8'b0000_1000,
      ST_MUL     = 8'b0001_0000,
      ST_RUN     = 8'b0010_0000,
      ST_DIV     = 8'b0100_0000,
      ST_OUT     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [DIM_W-1:0] src_width_ff, src_width_in;
   logic [DIM_W-1:0] src_height_ff, src_height_in;
   logic [TB_W-1:0]  texel_bytes_ff, texel_bytes_in;
   logic [DIM_W-1:0] max_width_ff, max_width_in;
   logic [DIM_W-1:0] max_height_ff, max_height_in;

   logic [DIM_W-1:0] bw_ff, bw_in;
   logic [DIM_W-1:0] bh_ff, bh_in;
   logic [DIM_W-1:0] ow_ff, ow_in;
   logic [DIM_W-1:0] oh_ff, oh_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [DIM_W-1:0]  sx_ff, sx_in;
   logic [DIM_W-1:0]  sy_ff, sy_in;
   logic [DIM_W-1:0]  bx_ff, bx_in;
   logic [DIM_W-1:0]  by_ff, by_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic                  s2_valid_ff, s2_valid_in;
   logic [3*CHAN_W-1:0]   s2_texel_ff, s2_texel_in;
   logic [SLOT_W-1:0]     s2_slot_ff, s2_slot_in;
   logic                  s2_first_ff, s2_first_in;
   logic                  s2_complete_ff, s2_complete_in;
   logic                  s2_last_ff, s2_last_in;
   logic                  last_pend_ff, last_pend_in;

   logic              wr_valid_ff, wr_valid_in;
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;
   logic [LINE_W-1:0] wr_data_ff, wr_data_in;
   logic [LINE_W-1:0] rd_data_ff;
   logic [LINE_W-1:0] line_mem [MAX_WIDTH];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0] rsp_red_ff, rsp_red_in;
   logic [CHAN_W-1:0] rsp_green_ff, rsp_green_in;
   logic [CHAN_W-1:0] rsp_blue_ff, rsp_blue_in;
   logic [CHAN_W-1:0] rsp_alpha_ff, rsp_alpha_in;
   logic [DIM_W-1:0]  rsp_cols_ff, rsp_cols_in;
   logic [DIM_W-1:0]  rsp_rows_ff, rsp_rows_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_rejected_ff, rsp_rejected_in;

   logic              cfg_ok;
   logic              csr_hit;
   logic              out_free;
   logic              ready;
   logic              accept;
   logic [DIM_W-1:0]  mw_eff;
   logic [DIM_W-1:0]  mh_eff;
   logic [DIM_W-1:0]  step_pick;
   logic [LINE_W-1:0] sum_base;
   logic [SUM_W-1:0]  sum_new_a, sum_new_b, sum_new_c;
   logic [LINE_W-1:0] sum_new;

   logic              div_start, div_start_c;
   logic [SUM_W-1:0]  dend_a, dend_b;
   logic [CNT_W-1:0]  dsor_a, dsor_b;
   logic [SUM_W-1:0]  quo_a, quo_b, quo_c;
   div_stat_type      stat_a, stat_b, stat_c;

   ibd_div u_div_a (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dend_a),
      .divisor  (dsor_a),
      .quotient (quo_a),
      .status   (stat_a)
   );

   ibd_div u_div_b (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dend_b),
      .divisor  (dsor_b),
      .quotient (quo_b),
      .status   (stat_b)
   );

   ibd_div u_div_c (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_c),
      .dividend (sum_new_c),
      .divisor  (cnt_ff),
      .quotient (quo_c),
      .status   (stat_c)
   );

   assign cfg_ok   = (src_width_ff != '0) && (src_height_ff != '0)
                     && (texel_bytes_ff >= MIN_TEXEL_BYTES);
   assign csr_hit  = csr_write && (csr_index <= CSR_MAX_HEIGHT);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ready    = (state_ff == ST_RUN)
                     && (cfg_ok ? !(s2_valid_ff && s2_complete_ff) : out_free);
   assign req_stall = !ready;
   assign accept    = req_valid && ready;
   assign mw_eff    = (max_width_ff == '0) ? DIM_W'(1) : max_width_ff;
   assign mh_eff    = (max_height_ff == '0) ? DIM_W'(1) : max_height_ff;

   // The previous beat's write lands on the same edge as this beat's read, so it is forwarded.
   always_comb begin
      if (s2_first_ff) begin
         sum_base = '0;
      end else if (wr_valid_ff && (wr_slot_ff == s2_slot_ff)) begin
         sum_base = wr_data_ff;
      end else begin
         sum_base = rd_data_ff;
      end
      sum_new_a = sum_base[SUM_W-1:0] + SUM_W'(s2_texel_ff[CHAN_W-1:0]);
      sum_new_b = sum_base[2*SUM_W-1:SUM_W] + SUM_W'(s2_texel_ff[2*CHAN_W-1:CHAN_W]);
      sum_new_c = sum_base[3*SUM_W-1:2*SUM_W] + SUM_W'(s2_texel_ff[3*CHAN_W-1:2*CHAN_W]);
      sum_new   = {sum_new_c, sum_new_b, sum_new_a};
   end

   always_comb begin
      step_pick = (quo_a[DIM_W-1:0] > quo_b[DIM_W-1:0]) ? quo_a[DIM_W-1:0]
                                                        : quo_b[DIM_W-1:0];
      if (step_pick == '0) begin
         step_pick = DIM_W'(1);
      end
   end

   always_comb begin
      state_in       = state_ff;
      src_width_in   = src_width_ff;
      src_height_in  = src_height_ff;
      texel_bytes_in = texel_bytes_ff;
      max_width_in   = max_width_ff;
      max_height_in  = max_height_ff;
      bw_in          = bw_ff;
      bh_in          = bh_ff;
      ow_in          = ow_ff;
      oh_in          = oh_ff;
      cnt_in         = cnt_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      bx_in          = bx_ff;
      by_in          = by_ff;
      slot_in        = slot_ff;
      s2_valid_in    = 1'b0;
      s2_texel_in    = s2_texel_ff;
      s2_slot_in     = s2_slot_ff;
      s2_first_in    = s2_first_ff;
      s2_complete_in = s2_complete_ff;
      s2_last_in     = s2_last_ff;
      last_pend_in   = last_pend_ff;
      wr_valid_in    = s2_valid_ff;
      wr_slot_in     = s2_slot_ff;
      wr_data_in     = sum_new;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_red_in     = rsp_red_ff;
      rsp_green_in   = rsp_green_ff;
      rsp_blue_in    = rsp_blue_ff;
      rsp_alpha_in   = rsp_alpha_ff;
      rsp_cols_in    = rsp_cols_ff;
      rsp_rows_in    = rsp_rows_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_rejected_in = rsp_rejected_ff;
      div_start      = 1'b0;
      div_start_c    = 1'b0;
      dend_a         = sum_new_a;
      dend_b         = sum_new_b;
      dsor_a         = cnt_ff;
      dsor_b         = cnt_ff;

      case (state_ff)
         ST_SETUP_A: begin
            if (cfg_ok) begin
               div_start = 1'b1;
               dend_a    = SUM_W'(src_width_ff);
               dsor_a    = CNT_W'(mw_eff);
               dend_b    = SUM_W'(src_height_ff);
               dsor_b    = CNT_W'(mh_eff);
               state_in  = ST_WAIT_A;
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_WAIT_A: begin
            if (stat_a.done) begin
               bw_in    = (step_pick < src_width_ff) ? step_pick : src_width_ff;
               bh_in    = (step_pick < src_height_ff) ? step_pick : src_height_ff;
               state_in = ST_SETUP_B;
            end
         end
         ST_SETUP_B: begin
            div_start = 1'b1;
            dend_a    = SUM_W'(src_width_ff);
            dsor_a    = CNT_W'(bw_ff);
            dend_b    = SUM_W'(src_height_ff);
            dsor_b    = CNT_W'(bh_ff);
            state_in  = ST_WAIT_B;
         end
         ST_WAIT_B: begin
            if (stat_a.done) begin
               ow_in    = quo_a[DIM_W-1:0];
               oh_in    = quo_b[DIM_W-1:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cnt_in   = CNT_W'(bw_ff) * CNT_W'(bh_ff);
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (accept && cfg_ok) begin
               s2_valid_in    = (bx_ff < ow_ff) && (by_ff < oh_ff);
               s2_texel_in    = {req_chan_c, req_chan_b, req_chan_a};
               s2_slot_in     = slot_ff;
               s2_first_in    = (sx_ff == '0) && (sy_ff == '0);
               s2_complete_in = (sx_ff == bw_ff - DIM_W'(1)) && (sy_ff == bh_ff - DIM_W'(1));
               s2_last_in     = (bx_ff == ow_ff - DIM_W'(1)) && (by_ff == oh_ff - DIM_W'(1));
               if (col_ff == src_width_ff - DIM_W'(1)) begin
                  col_in  = '0;
                  sx_in   = '0;
                  bx_in   = '0;
                  slot_in = '0;
                  if (row_ff == src_height_ff - DIM_W'(1)) begin
                     row_in = '0;
                     sy_in  = '0;
                     by_in  = '0;
                  end else begin
                     row_in = row_ff + DIM_W'(1);
                     if (sy_ff == bh_ff - DIM_W'(1)) begin
                        sy_in = '0;
                        by_in = by_ff + DIM_W'(1);
                     end else begin
                        sy_in = sy_ff + DIM_W'(1);
                     end
                  end
               end else begin
                  col_in = col_ff + DIM_W'(1);
                  if (sx_ff == bw_ff - DIM_W'(1)) begin
                     sx_in   = '0;
                     bx_in   = bx_ff + DIM_W'(1);
                     slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
                  end else begin
                     sx_in = sx_ff + DIM_W'(1);
                  end
               end
            end else if (accept) begin
               rsp_valid_in    = 1'b1;
               rsp_red_in      = '0;
               rsp_green_in    = '0;
               rsp_blue_in     = '0;
               rsp_alpha_in    = '0;
               rsp_cols_in     = '0;
               rsp_rows_in     = '0;
               rsp_last_in     = 1'b0;
               rsp_rejected_in = 1'b1;
            end
            if (s2_valid_ff && s2_complete_ff) begin
               div_start    = 1'b1;
               div_start_c  = 1'b1;
               last_pend_in = s2_last_ff;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat_a.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_red_in      = quo_a[CHAN_W-1:0];
               rsp_green_in    = quo_b[CHAN_W-1:0];
               rsp_blue_in     = quo_c[CHAN_W-1:0];
               rsp_alpha_in    = ALPHA_OPAQUE;
               rsp_cols_in     = ow_ff;
               rsp_rows_in     = oh_ff;
               rsp_last_in     = last_pend_ff;
               rsp_rejected_in = 1'b0;
               state_in        = ST_RUN;
            end
         end
         default: begin
            state_in = ST_SETUP_A;
         end
      endcase

      // A write to a defined register restarts the frame and recomputes the box geometry.
      if (csr_hit) begin
         case (csr_index)
            CSR_SRC_WIDTH:   src_width_in   = csr_wdata;
            CSR_SRC_HEIGHT:  src_height_in  = csr_wdata;
            CSR_TEXEL_BYTES: texel_bytes_in = csr_wdata[TB_W-1:0];
            CSR_MAX_WIDTH:   max_width_in   = csr_wdata;
            CSR_MAX_HEIGHT:  max_height_in  = csr_wdata;
            default:         src_width_in   = src_width_ff;
         endcase
         col_in   = '0;
         row_in   = '0;
         sx_in    = '0;
         sy_in    = '0;
         bx_in    = '0;
         by_in    = '0;
         slot_in  = '0;
         state_in = ST_SETUP_A;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SETUP_A;
         src_width_ff   <= '0;
         src_height_ff  <= '0;
         texel_bytes_ff <= 4'd4;
         max_width_ff   <= 13'd256;
         max_height_ff  <= 13'd256;
         col_ff         <= '0;
         row_ff         <= '0;
         sx_ff          <= '0;
         sy_ff          <= '0;
         bx_ff          <= '0;
         by_ff          <= '0;
         slot_ff        <= '0;
         s2_valid_ff    <= 1'b0;
         wr_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         src_width_ff   <= src_width_in;
         src_height_ff  <= src_height_in;
         texel_bytes_ff <= texel_bytes_in;
         max_width_ff   <= max_width_in;
         max_height_ff  <= max_height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         sx_ff          <= sx_in;
         sy_ff          <= sy_in;
         bx_ff          <= bx_in;
         by_ff          <= by_in;
         slot_ff        <= slot_in;
         s2_valid_ff    <= s2_valid_in;
         wr_valid_ff    <= wr_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      bw_ff           <= bw_in;
      bh_ff           <= bh_in;
      ow_ff           <= ow_in;
      oh_ff           <= oh_in;
      cnt_ff          <= cnt_in;
      s2_texel_ff     <= s2_texel_in;
      s2_slot_ff      <= s2_slot_in;
      s2_first_ff     <= s2_first_in;
      s2_complete_ff  <= s2_complete_in;
      s2_last_ff      <= s2_last_in;
      last_pend_ff    <= last_pend_in;
      wr_slot_ff      <= wr_slot_in;
      wr_data_ff      <= wr_data_in;
      rsp_red_ff      <= rsp_red_in;
      rsp_green_ff    <= rsp_green_in;
      rsp_blue_ff     <= rsp_blue_in;
      rsp_alpha_ff    <= rsp_alpha_in;
      rsp_cols_ff     <= rsp_cols_in;
      rsp_rows_ff     <= rsp_rows_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_rejected_ff <= rsp_rejected_in;
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         line_mem[s2_slot_ff] <= sum_new;
      end
      if (accept) begin
         rd_data_ff <= line_mem[slot_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;
   assign rsp_alpha      = rsp_alpha_ff;
   assign rsp_out_cols   = rsp_cols_ff;
   assign rsp_out_rows   = rsp_rows_ff;
   assign rsp_last_pixel = rsp_last_ff;
   assign rsp_rejected   = rsp_rejected_ff;

   `IBD_ASSERT_SAME(a_accept_in_run, accept, state_ff == ST_RUN, "beat accepted outside run state")
   `IBD_ASSERT_NEXT(a_box_starts_divide, s2_valid_ff && s2_complete_ff && !csr_hit,
                    state_ff == ST_DIV, "completed box did not start the divide")
   `IBD_ASSERT_SAME(a_dividers_in_step, state_ff == ST_DIV,
                    (stat_a == stat_b) && (stat_a == stat_c), "average dividers out of step")
   `IBD_ASSERT_SAME(a_pixel_from_out, $rose(rsp_valid_ff) && !rsp_rejected_ff,
                    $past(state_ff == ST_OUT), "pixel beat not loaded from output state")
   `IBD_ASSERT_SAME(a_column_in_box, (state_ff == ST_RUN) && cfg_ok, sx_ff < bw_ff,
                    "column offset escaped the box")

endmodule

// ----- tb/image_box_downscale_checker.sv -----
`timescale 1ns / 1ps
// Checker for the image box downscaler: follows register writes and accepted texel beats,
// forms the expected thumbnail pixels and compares every result beat with the oldest one.
// Depends on ibd_pkg for widths, register indexes and constants.
module image_box_downscale_checker import ibd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [CHAN_W-1:0]    req_chan_a,
   input  logic [CHAN_W-1:0]    req_chan_b,
   input  logic [CHAN_W-1:0]    req_chan_c,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [CHAN_W-1:0]    rsp_red,
   input  logic [CHAN_W-1:0]    rsp_green,
   input  logic [CHAN_W-1:0]    rsp_blue,
   input  logic [CHAN_W-1:0]    rsp_alpha,
   input  logic [DIM_W-1:0]     rsp_out_cols,
   input  logic [DIM_W-1:0]     rsp_out_rows,
   input  logic                 rsp_last_pixel,
   input  logic                 rsp_rejected,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   output int                   mismatch_count,
   output int                   pixels_due
);

   localparam int LINE_DEPTH = 4096;
   localparam int PRINT_CAP  = 200;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic [DIM_W-1:0]  out_cols;
      logic [DIM_W-1:0]  out_rows;
      logic              last_pixel;
      logic              rejected;
   } thumb_pixel_t;

   logic [DIM_W-1:0] src_w;
   logic [DIM_W-1:0] src_h;
   logic [DIM_W-1:0] max_w;
   logic [DIM_W-1:0] max_h;
   logic [TB_W-1:0]  texel_bytes;
   logic [DIM_W-1:0] box_step;
   logic [SUM_W-1:0] sum_r [LINE_DEPTH];
   logic [SUM_W-1:0] sum_g [LINE_DEPTH];
   logic [SUM_W-1:0] sum_b [LINE_DEPTH];
   int unsigned      col;
   int unsigned      row;
   bit               step_known;
   thumb_pixel_t     thumb_due[$];

   initial begin
      mismatch_count = 0;
      pixels_due = 0;
   end

   function automatic int unsigned choose_step();
      int unsigned mw;
      int unsigned mh;
      int unsigned s;
      mw = (max_w == 0) ? 1 : max_w;
      mh = (max_h == 0) ? 1 : max_h;
      s = 1;
      while (src_w / (s + 1) >= mw || src_h / (s + 1) >= mh) s++;
      return s;
   endfunction

   task automatic average_texel(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b,
                                input logic [CHAN_W-1:0] c);
      int unsigned  bw;
      int unsigned  bh;
      int unsigned  ow;
      int unsigned  oh;
      int unsigned  bx;
      int unsigned  by;
      int unsigned  slot;
      int unsigned  cnt;
      thumb_pixel_t px;
      px = '0;
      if (src_w == 0 || src_h == 0 || texel_bytes < MIN_TEXEL_BYTES) begin
         px.rejected = 1'b1;
         thumb_due.push_back(px);
      end else begin
         if (!step_known) begin
            box_step = choose_step();
            if (box_step == 0) box_step = 1;
            step_known = 1'b1;
         end
         bw = (box_step < src_w) ? box_step : src_w;
         bh = (box_step < src_h) ? box_step : src_h;
         ow = src_w / bw;
         oh = src_h / bh;
         if (col < ow * bw && row < oh * bh) begin
            bx = col / bw;
            by = row / bh;
            slot = bx % LINE_DEPTH;
            if (col % bw == 0 && row % bh == 0) begin
               sum_r[slot] = a;
               sum_g[slot] = b;
               sum_b[slot] = c;
            end else begin
               sum_r[slot] = sum_r[slot] + a;
               sum_g[slot] = sum_g[slot] + b;
               sum_b[slot] = sum_b[slot] + c;
            end
            if (col % bw == bw - 1 && row % bh == bh - 1) begin
               cnt = bw * bh;
               px.red = sum_r[slot] / cnt;
               px.green = sum_g[slot] / cnt;
               px.blue = sum_b[slot] / cnt;
               px.alpha = ALPHA_OPAQUE;
               px.out_cols = ow;
               px.out_rows = oh;
               px.last_pixel = (bx == ow - 1) && (by == oh - 1);
               thumb_due.push_back(px);
            end
         end
         col++;
         if (col >= src_w) begin
            col = 0;
            row++;
            if (row >= src_h) begin
               row = 0;
               step_known = 1'b0;
            end
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP) $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [DIM_W-1:0] got,
                              input logic [DIM_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      thumb_pixel_t want;
      bit           restart;
      if (reset) begin
         src_w = '0;
         src_h = '0;
         texel_bytes = 4'd4;
         max_w = 13'd256;
         max_h = 13'd256;
         box_step = 13'd1;
         col = 0;
         row = 0;
         step_known = 1'b0;
         thumb_due.delete();
      end else begin
         if (csr_write) begin
            restart = 1'b1;
            case (csr_index)
               CSR_SRC_WIDTH: src_w = csr_wdata;
               CSR_SRC_HEIGHT: src_h = csr_wdata;
               CSR_TEXEL_BYTES: texel_bytes = csr_wdata[TB_W-1:0];
               CSR_MAX_WIDTH: max_w = csr_wdata;
               CSR_MAX_HEIGHT: max_h = csr_wdata;
               default: restart = 1'b0;
            endcase
            if (restart) begin
               col = 0;
               row = 0;
               step_known = 1'b0;
            end
         end
         if (req_valid && !req_stall) average_texel(req_chan_a, req_chan_b, req_chan_c);
         if (rsp_valid && !rsp_stall) begin
            if (thumb_due.size() == 0) begin
               report_mismatch("result beat with no pixel outstanding");
            end else begin
               want = thumb_due.pop_front();
               check_field("red", rsp_red, want.red);
               check_field("green", rsp_green, want.green);
               check_field("blue", rsp_blue, want.blue);
               check_field("alpha", rsp_alpha, want.alpha);
               check_field("out_cols", rsp_out_cols, want.out_cols);
               check_field("out_rows", rsp_out_rows, want.out_rows);
               check_field("last_pixel", rsp_last_pixel, want.last_pixel);
               check_field("rejected", rsp_rejected, want.rejected);
            end
         end
      end
      pixels_due = thumb_due.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the image box downscaler testbench: clock, reset, texel and register stimulus.
// Depends on ibd_pkg, image_box_downscale and image_box_downscale_checker.
module testbench;
   import ibd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd5;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int TOTAL_TEXELS  = 990;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [CHAN_W-1:0]    req_chan_a;
   logic [CHAN_W-1:0]    req_chan_b;
   logic [CHAN_W-1:0]    req_chan_c;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [CHAN_W-1:0]    rsp_red;
   logic [CHAN_W-1:0]    rsp_green;
   logic [CHAN_W-1:0]    rsp_blue;
   logic [CHAN_W-1:0]    rsp_alpha;
   logic [DIM_W-1:0]     rsp_out_cols;
   logic [DIM_W-1:0]     rsp_out_rows;
   logic                 rsp_last_pixel;
   logic                 rsp_rejected;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;
   int                   mismatch_count;
   int                   pixels_due;
   int                   send_idle_pct;
   int                   recv_idle_pct;
   bit                   hold_req;
   int                   texels_sent;

   image_box_downscale dut (.*);
   image_box_downscale_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("image_box_downscale: mismatch");
      $finish;
   end

   // The receiver stalls at random, or for one long stretch when asked to hold off.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [CHAN_W-1:0] rand_byte();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return $urandom_range(255);
      endcase
   endfunction

   task automatic send_texel(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b,
                             input logic [CHAN_W-1:0] c);
      if (texels_sent < 330) begin
         send_idle_pct = 25;
         recv_idle_pct = 87;
      end else if (texels_sent < 660) begin
         send_idle_pct = 87;
         recv_idle_pct = 25;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_chan_a = a;
      req_chan_b = b;
      req_chan_c = c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
      texels_sent++;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_texel(rand_byte(), rand_byte(), rand_byte());
   endtask

   task automatic wait_results();
      while (pixels_due != 0) @(negedge clock);
   endtask

   task automatic wait_idle();
      wait_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_write = 1'b0;
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_frame(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                            input logic [DIM_W-1:0] tb, input logic [DIM_W-1:0] mw,
                            input logic [DIM_W-1:0] mh);
      write_reg(CSR_SRC_WIDTH, sw);
      write_reg(CSR_SRC_HEIGHT, sh);
      write_reg(CSR_TEXEL_BYTES, tb);
      write_reg(CSR_MAX_WIDTH, mw);
      write_reg(CSR_MAX_HEIGHT, mh);
   endtask

   initial begin
      int unsigned sw;
      int unsigned sh;
      int unsigned area;
      int          count;
      int          first_part;
      reset = 1'b1;
      req_valid = 1'b0;
      req_chan_a = '0;
      req_chan_b = '0;
      req_chan_c = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_req = 1'b0;
      texels_sent = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (SETTLE_CYCLES) @(negedge clock);

      // Default registers have a zero source size, so the first beat is rejected.
      send_texel(8'h00, 8'hFF, 8'h5A);
      wait_idle();

      // One 2x2 box filling the whole thumbnail.
      set_frame(2, 2, 3, 1, 1);
      send_texel(8'hFF, 8'h00, 8'hFF);
      send_texel(8'hFF, 8'h00, 8'h00);
      send_texel(8'hFF, 8'h00, 8'hFF);
      send_texel(8'hFF, 8'h00, 8'h00);
      wait_idle();

      // Only the low nibble counts for texel bytes; two bytes is rejected.
      write_reg(CSR_TEXEL_BYTES, 13'h0012);
      send_texel(8'h12, 8'h34, 8'h56);
      wait_idle();

      // A zero maximum acts as one, and the box is clipped to a single row.
      set_frame(3, 1, 13'h1FF3, 0, 4096);
      send_texel(8'hFF, 8'h01, 8'h80);
      send_texel(8'hFF, 8'hFF, 8'h80);
      send_texel(8'h01, 8'h00, 8'h81);
      wait_idle();

      // Trailing column and row are dropped; an unused index leaves the frame running.
      set_frame(5, 3, 8, 2, 2);
      send_random(7);
      wait_idle();
      write_reg(CSR_UNUSED, 13'h1ABC);
      send_random(8);
      wait_idle();

      write_reg(CSR_SRC_HEIGHT, 0);
      send_texel(8'hA5, 8'h5A, 8'hC3);
      wait_idle();

      // The receiver holds off while the sender keeps offering beats.
      set_frame(8, 8, 4, 16, 16);
      hold_req = 1'b1;
      send_random(64);
      wait_idle();

      while (texels_sent < TOTAL_TEXELS) begin
         case ($urandom_range(15))
            0: begin
               case ($urandom_range(2))
                  0: set_frame(0, $urandom_range(1, 8), 3, $urandom_range(8191),
                               $urandom_range(8191));
                  1: set_frame($urandom_range(1, 8), 0, 4, $urandom_range(8191),
                               $urandom_range(8191));
                  default: set_frame($urandom_range(1, 8), $urandom_range(1, 8),
                                     ($urandom_range(511) << 4) | $urandom_range(2),
                                     $urandom_range(12), $urandom_range(12));
               endcase
               count = $urandom_range(3, 10);
            end
            1: begin
               set_frame($urandom_range(4000, 8191), $urandom_range(4000, 8191),
                         ($urandom_range(511) << 4) | $urandom_range(3, 15),
                         $urandom_range(8191), $urandom_range(8191));
               count = $urandom_range(5, 20);
            end
            default: begin
               sw = $urandom_range(1, 10);
               sh = $urandom_range(1, 10);
               area = sw * sh;
               set_frame(sw, sh, ($urandom_range(511) << 4) | $urandom_range(3, 15),
                         $urandom_range(12), $urandom_range(12));
               count = $urandom_range(1, 2) * area + $urandom_range(area - 1);
            end
         endcase
         first_part = ($urandom_range(3) == 0) ? count / 2 : count;
         send_random(first_part);
         wait_results();
         send_random(count - first_part);
         wait_idle();
      end

      wait_idle();
      if (mismatch_count == 0 && pixels_due == 0) begin
         $display("image_box_downscale: match");
      end else begin
         $display("image_box_downscale: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/ibd_pkg.sv
src/ibd_div.sv
src/image_box_downscale.sv
tb/image_box_downscale_checker.sv
tb/testbench.sv
